// File: design/lmsf_pkg.sv
// lmsf_pkg: shared widths, constants, state type and the command/status structs
// of the lms adaptive fir block
// no dependencies
package lmsf_pkg;

    localparam int TAPS_DEF         = 128;
    localparam int WEIGHT_WIDTH_DEF = 32;

    localparam int SAMPLE_W = 16;
    localparam int ERR_W    = 17;
    localparam int STEP_W   = 24;
    localparam int ACC_W    = 64;
    localparam int ACC_FRAC = 30;

    localparam logic [STEP_W-1:0] STEP_RESET = 24'd1678;

    localparam int ERR_HI = 65535;
    localparam int ERR_LO = -65536;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILT,
        ST_FDRAIN,
        ST_EMU,
        ST_UPD,
        ST_UDRAIN,
        ST_OUT
    } lmsf_state_t;

    typedef struct packed {
        logic clr;       // write zero at tap counter into both memories
        logic load;      // take the new sample, clear accumulator
        logic issue;     // read one tap and advance the tap counter
        logic upd;       // pipeline works on the weight update pass
        logic calc_err;  // form error and clamped output from accumulator
        logic calc_emu;  // form mu*error and the scaled output
        logic out_load;  // move the result into the output register
    } lmsf_cmd_t;

    typedef struct packed {
        logic tap_last;
        logic pipe_busy;
        logic out_free;
    } lmsf_stat_t;

endpackage

// File: design/lmsf_ram.sv
// lmsf_ram: generic single write port, single read port ram with registered read
// no dependencies
module lmsf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/lmsf_ctrl.sv
// lmsf_ctrl: sequencer for clear pass, filter pass, error step and update pass
// depends on lmsf_pkg
module lmsf_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lmsf_pkg::lmsf_stat_t stat,
    output lmsf_pkg::lmsf_cmd_t  cmd
);
    import lmsf_pkg::*;

    lmsf_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr = 1'b1;
                if (stat.tap_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_FILT;
                end
            end
            ST_FILT: begin
                cmd.issue = 1'b1;
                if (stat.tap_last) begin
                    state_next = ST_FDRAIN;
                end
            end
            ST_FDRAIN: begin
                // accumulator is final once the last product has gone in
                if (!stat.pipe_busy) begin
                    cmd.calc_err = 1'b1;
                    state_next   = ST_EMU;
                end
            end
            ST_EMU: begin
                cmd.calc_emu = 1'b1;
                state_next   = ST_UPD;
            end
            ST_UPD: begin
                cmd.upd   = 1'b1;
                cmd.issue = 1'b1;
                if (stat.tap_last) begin
                    state_next = ST_UDRAIN;
                end
            end
            ST_UDRAIN: begin
                cmd.upd = 1'b1;
                if (!stat.pipe_busy) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// File: design/lmsf_dpath.sv
// lmsf_dpath: delay line and weight memories, shared multiplier, accumulator,
// error and update arithmetic, output register; depends on lmsf_pkg, lmsf_ram
module lmsf_dpath #(
    parameter int TAPS         = 128,
    parameter int WEIGHT_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  lmsf_pkg::lmsf_cmd_t                   cmd,
    output lmsf_pkg::lmsf_stat_t                  stat,
    input  logic signed [lmsf_pkg::SAMPLE_W-1:0]  sample_in,
    input  logic                                  step_size_we,
    input  logic [lmsf_pkg::STEP_W-1:0]           step_size_wdata,
    input  logic                                  m_ready,
    output logic                                  m_valid,
    output logic signed [lmsf_pkg::SAMPLE_W-1:0]  filtered_out,
    output logic signed [lmsf_pkg::ERR_W-1:0]     error_out
);
    import lmsf_pkg::*;

    localparam int IDX_W   = $clog2(TAPS);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(TAPS - 1);
    localparam int WFRAC   = WEIGHT_WIDTH - 5;
    localparam int EMU_W   = ERR_W + STEP_W + 1;
    localparam int MUL_A_W = (WEIGHT_WIDTH > EMU_W) ? WEIGHT_WIDTH : EMU_W;
    localparam int PROD_W  = MUL_A_W + SAMPLE_W;
    localparam int ALIGN   = WFRAC + (SAMPLE_W - 1) - ACC_FRAC;
    localparam int SHR     = (ALIGN >= 0) ? ALIGN : 0;
    localparam int SHL     = (ALIGN < 0) ? -ALIGN : 0;
    localparam int USH     = 2 * (SAMPLE_W - 1) + STEP_W - WFRAC;
    localparam int Y_SHIFT = ACC_FRAC - (SAMPLE_W - 1);
    localparam int YC_W    = ACC_FRAC + 2;
    localparam int SC_W    = YC_W + SAMPLE_W - 1;

    localparam logic signed [ACC_W-1:0] ONE      = ACC_W'(1);
    localparam logic signed [ACC_W-1:0] RND_HALF = ONE <<< (USH - 1);
    localparam logic signed [ACC_W-1:0] W_HI     = (ONE <<< (WEIGHT_WIDTH - 1)) - ONE;
    localparam logic signed [ACC_W-1:0] W_LO     = -W_HI - ONE;
    localparam logic signed [ACC_W-1:0] E_HI     = ACC_W'(ERR_HI);
    localparam logic signed [ACC_W-1:0] E_LO     = ACC_W'(ERR_LO);
    localparam logic signed [ACC_W-1:0] Y_HI     = ONE <<< ACC_FRAC;
    localparam logic signed [ACC_W-1:0] Y_LO     = -Y_HI;
    localparam logic signed [SC_W-1:0]  TRUNC_BIAS = (SC_W'(1) <<< ACC_FRAC) - SC_W'(1);

    // tap counter and circular delay line pointers
    logic [IDX_W-1:0] tap_reg, tap_next;
    logic [IDX_W-1:0] base_reg, base_next;
    logic [IDX_W-1:0] dptr_reg, dptr_next;
    logic [IDX_W-1:0] base_dec;

    logic                    d_we;
    logic [IDX_W-1:0]        d_waddr;
    logic [SAMPLE_W-1:0]     d_wdata, d_rdata;
    logic                    w_we;
    logic [IDX_W-1:0]        w_waddr;
    logic [WEIGHT_WIDTH-1:0] w_wdata, w_rdata;

    logic                       s1_vld_reg, s2_vld_reg;
    logic [IDX_W-1:0]           wk1_reg, wk2_reg;
    logic signed [WEIGHT_WIDTH-1:0] w_d_reg;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    aligned, rsum, dlt, wsum;
    logic signed [WEIGHT_WIDTH-1:0] w_new;

    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [ACC_W-1:0]    y15, diff, ysat;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [YC_W-1:0]     yc_reg;
    logic signed [EMU_W-1:0]    emu_reg;
    logic signed [SC_W-1:0]     sc, sc_b;
    logic signed [SAMPLE_W-1:0] filt_reg;
    logic [STEP_W-1:0]          step_reg;

    logic                       out_vld_reg;
    logic signed [SAMPLE_W-1:0] out_filt_reg;
    logic signed [ERR_W-1:0]    out_err_reg;

    assign base_dec = (base_reg == '0) ? LAST : base_reg - 1'b1;

    always_comb begin
        tap_next  = tap_reg;
        base_next = base_reg;
        dptr_next = dptr_reg;
        if (cmd.clr || cmd.issue) begin
            tap_next = (tap_reg == LAST) ? '0 : tap_reg + 1'b1;
        end
        if (cmd.load) begin
            base_next = base_dec;
            dptr_next = base_dec;
        end else if (cmd.issue) begin
            dptr_next = (dptr_reg == LAST) ? '0 : dptr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_reg     <= '0;
            base_reg    <= '0;
            dptr_reg    <= '0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            step_reg    <= STEP_RESET;
        end else begin
            tap_reg    <= tap_next;
            base_reg   <= base_next;
            dptr_reg   <= dptr_next;
            s1_vld_reg <= cmd.issue;
            s2_vld_reg <= s1_vld_reg;
            if (step_size_we) begin
                step_reg <= step_size_wdata;
            end
            if (cmd.out_load) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // newest sample goes one slot below the old head
    assign d_we    = cmd.clr | cmd.load;
    assign d_waddr = cmd.clr ? tap_reg : base_dec;
    assign d_wdata = cmd.clr ? '0 : sample_in;

    assign w_we    = cmd.clr | (s2_vld_reg & cmd.upd);
    assign w_waddr = cmd.clr ? tap_reg : wk2_reg;
    assign w_wdata = cmd.clr ? '0 : w_new;

    lmsf_ram #(.WIDTH(SAMPLE_W), .DEPTH(TAPS)) u_delay_ram (
        .aclk  (aclk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .raddr (dptr_reg),
        .rdata (d_rdata)
    );

    lmsf_ram #(.WIDTH(WEIGHT_WIDTH), .DEPTH(TAPS)) u_weight_ram (
        .aclk  (aclk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .raddr (tap_reg),
        .rdata (w_rdata)
    );

    // one multiplier: weight*x while filtering, mu*err*x while updating
    assign mul_a = cmd.upd ? MUL_A_W'(emu_reg) : MUL_A_W'($signed(w_rdata));

    always_ff @(posedge aclk) begin
        wk1_reg  <= tap_reg;
        wk2_reg  <= wk1_reg;
        w_d_reg  <= $signed(w_rdata);
        prod_reg <= PROD_W'(mul_a) * PROD_W'($signed(d_rdata));
    end

    always_comb begin
        aligned = (ACC_W'(prod_reg) >>> SHR) <<< SHL;
        rsum    = ACC_W'(prod_reg) + RND_HALF;
        dlt     = rsum >>> USH;
        wsum    = ACC_W'(w_d_reg) + dlt;
        if (wsum > W_HI) begin
            w_new = WEIGHT_WIDTH'(W_HI);
        end else if (wsum < W_LO) begin
            w_new = WEIGHT_WIDTH'(W_LO);
        end else begin
            w_new = WEIGHT_WIDTH'(wsum);
        end
    end

    always_comb begin
        y15  = acc_reg >>> Y_SHIFT;
        diff = ACC_W'(x_reg) - y15;
        if (acc_reg > Y_HI) begin
            ysat = Y_HI;
        end else if (acc_reg < Y_LO) begin
            ysat = Y_LO;
        end else begin
            ysat = acc_reg;
        end
        // times 32767 as (y << 15) - y, then divide toward zero
        sc   = (SC_W'(yc_reg) <<< (SAMPLE_W - 1)) - SC_W'(yc_reg);
        sc_b = (sc < 0) ? sc + TRUNC_BIAS : sc;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg   <= sample_in;
            acc_reg <= '0;
        end else if (s2_vld_reg && !cmd.upd) begin
            acc_reg <= acc_reg + aligned;
        end
        if (cmd.calc_err) begin
            if (diff > E_HI) begin
                err_reg <= ERR_W'(E_HI);
            end else if (diff < E_LO) begin
                err_reg <= ERR_W'(E_LO);
            end else begin
                err_reg <= ERR_W'(diff);
            end
            yc_reg <= YC_W'(ysat);
        end
        if (cmd.calc_emu) begin
            emu_reg  <= EMU_W'(err_reg) * EMU_W'($signed({1'b0, step_reg}));
            filt_reg <= SAMPLE_W'(sc_b >>> ACC_FRAC);
        end
        if (cmd.out_load) begin
            out_filt_reg <= filt_reg;
            out_err_reg  <= err_reg;
        end
    end

    assign stat.tap_last  = (tap_reg == LAST);
    assign stat.pipe_busy = s1_vld_reg | s2_vld_reg;
    assign stat.out_free  = ~out_vld_reg | m_ready;

    assign m_valid      = out_vld_reg;
    assign filtered_out = out_filt_reg;
    assign error_out    = out_err_reg;

endmodule

// File: design/lms_adaptive_fir.sv
// lms_adaptive_fir: top level, joins the sequencer and the datapath
// depends on lmsf_pkg, lmsf_ctrl, lmsf_dpath, lmsf_ram
//
// LMS adaptive FIR filter with TAPS taps. Each accepted item is one Q1.15
// sample; the block returns one result item with the FIR output clamped to
// +-1 (Q1.15) and the saturated error (sample minus unclamped output, Q2.15),
// after which every weight has moved by mu*error*x[k]. A single multiplier
// walks the taps twice, once to filter and once to update the weights, so the
// result is offered only after both passes, and only once the output register
// is free; the next item is taken only after that result has been moved into
// the output register, so the block never works on two items at once.
// After reset a clearing pass over all taps zeroes the delay line and weight
// memories; no item is accepted during it. step_size (mu, unsigned Q0.24,
// reset 1678) may be written whenever the block is idle.
module lms_adaptive_fir #(
    parameter int TAPS         = lmsf_pkg::TAPS_DEF,
    parameter int WEIGHT_WIDTH = lmsf_pkg::WEIGHT_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [lmsf_pkg::SAMPLE_W-1:0] s_sample_in,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [lmsf_pkg::SAMPLE_W-1:0] m_filtered_out,
    output logic signed [lmsf_pkg::ERR_W-1:0]    m_error_out,
    input  logic                                 step_size_we,
    input  logic [lmsf_pkg::STEP_W-1:0]          step_size_wdata
);
    import lmsf_pkg::*;

    lmsf_cmd_t  cmd;
    lmsf_stat_t stat;

    lmsf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lmsf_dpath #(
        .TAPS         (TAPS),
        .WEIGHT_WIDTH (WEIGHT_WIDTH)
    ) u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .sample_in       (s_sample_in),
        .step_size_we    (step_size_we),
        .step_size_wdata (step_size_wdata),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .filtered_out    (m_filtered_out),
        .error_out       (m_error_out)
    );

    // a result never overwrites one that is still waiting
    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> stat.out_free)
        else $error("output register overwritten");

    // every tap read shows up in the pipeline
    a_issue_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue |=> stat.pipe_busy)
        else $error("tap read lost in pipeline");

    // a new item starts only with the pipeline empty
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> (!stat.pipe_busy && s_ready))
        else $error("item taken while pipeline busy");

    // the weight update pass never runs into an item load
    a_upd_no_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.upd |-> (!cmd.load && !s_ready))
        else $error("item taken during weight update");

endmodule
